// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sprite compositor.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define LSPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define LSPC_NEVER(lbl, cond, msg) \
  `LSPC_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/lspc_pkg.sv
// Shared types and codes of the layered sprite pixel compositor.
// Depends on nothing; used by every module of the block.
package lspc_pkg;

  typedef enum logic [2:0] {
    CMD_DRAW      = 3'd0,
    CMD_LAYER     = 3'd1,
    CMD_PART_SIZE = 3'd2,
    CMD_PIXEL     = 3'd3,
    CMD_PALETTE   = 3'd4
  } lspc_cmd_e;

  localparam logic REG_FRAME_ACTIVE = 1'b0;
  localparam logic REG_LAYER_COUNT  = 1'b1;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [5:0]         part;
    logic               rotate;
    logic [11:0]        start;
    logic signed [12:0] stride_x;
    logic signed [12:0] stride_y;
  } lspc_layer_t;

  typedef struct packed {
    logic part_size;
    logic pixel;
    logic palette;
  } lspc_wr_t;

  typedef struct packed {
    logic live;
    logic last;
  } lspc_ctl_t;

endpackage

// File: rtl/lspc_cell.sv
// One layer cell of the rotating layer ring.
// Depends on lspc_pkg for the layer record.
module lspc_cell (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic                 shift_i,
  input  lspc_pkg::lspc_layer_t wr_layer_i,
  input  lspc_pkg::lspc_layer_t nxt_layer_i,
  output lspc_pkg::lspc_layer_t layer_o
);
  import lspc_pkg::*;

  lspc_layer_t layer_q;

  // Load from the write port when idle, take the neighbor's record while drawing.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      layer_q <= wr_layer_i;
    end else if (shift_i) begin
      layer_q <= nxt_layer_i;
    end
  end

  assign layer_o = layer_q;

endmodule

// File: rtl/lspc_pipe.sv
// Per-layer pixel pipeline: part size, hit test, address, pixel and palette lookup.
// Depends on lspc_pkg; holds the part size, part pixel and palette memories.
module lspc_pipe #(
  parameter int PARTS        = 64,
  parameter int PIXELS       = 4096,
  parameter int PALETTE_SIZE = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lspc_pkg::lspc_wr_t    wr_i,
  input  logic [11:0]           wr_index_i,
  input  logic [31:0]           wr_value_i,
  input  logic [7:0]            wr_width_i,
  input  logic [7:0]            wr_height_i,
  input  lspc_pkg::lspc_ctl_t   issue_i,
  input  lspc_pkg::lspc_layer_t layer_i,
  input  logic signed [15:0]    px_i,
  input  logic signed [15:0]    py_i,
  output lspc_pkg::lspc_ctl_t   res_o,
  output logic [31:0]           color_o
);
  import lspc_pkg::*;

  localparam int PTW = (PARTS > 1) ? $clog2(PARTS) : 1;
  localparam int AW  = $clog2(PIXELS);
  localparam int PLW = $clog2(PALETTE_SIZE);
  // Bias that lifts any address sum above zero, and the reciprocal for the wrap.
  localparam int OffsInt = ((2 ** 21 + PIXELS - 1) / PIXELS) * PIXELS;
  localparam int RecInt  = (2 ** 23) / PIXELS;
  localparam logic [22:0] OFFS  = 23'(OffsInt);
  localparam logic [17:0] RECIP = 18'(RecInt);

  // Wrap tables for part number and palette index.
  logic [PTW-1:0] part_lut [64];
  logic [PLW-1:0] pal_lut  [256];

  for (genvar g = 0; g < 64; g++) begin : g_part_lut
    assign part_lut[g] = PTW'(g % PARTS);
  end
  for (genvar g = 0; g < 256; g++) begin : g_pal_lut
    assign pal_lut[g] = PLW'(g % PALETTE_SIZE);
  end

  logic [15:0] size_mem [PARTS];
  logic [7:0]  pix_mem  [PIXELS];
  logic [31:0] pal_mem  [PALETTE_SIZE];

  logic wr_size_ok, wr_pix_ok, wr_pal_ok;
  assign wr_size_ok = wr_i.part_size && ({1'b0, wr_index_i} < 13'(PARTS));
  assign wr_pix_ok  = wr_i.pixel && ({5'b0, wr_index_i} < 17'(PIXELS));
  assign wr_pal_ok  = wr_i.palette && ({1'b0, wr_index_i} < 13'(PALETTE_SIZE));

  lspc_ctl_t a_ctl_q, b_ctl_q, c_ctl_q, d_ctl_q, e_ctl_q, f_ctl_q, g_ctl_q, h_ctl_q;

  // Stage A: part size read.
  logic [15:0] a_size_q;
  lspc_layer_t a_layer_q;

  always_ff @(posedge clk_i) begin
    if (wr_size_ok) begin
      size_mem[PTW'(wr_index_i)] <= {wr_height_i, wr_width_i};
    end
    a_size_q  <= size_mem[part_lut[layer_i.part]];
    a_layer_q <= layer_i;
  end

  // Stage B: hit test and offsets inside the layer.
  logic [7:0]  eff_w, eff_h;
  logic [16:0] dx, dy;
  logic        hit;
  logic [7:0]  b_dx_q, b_dy_q;
  logic signed [12:0] b_sx_q, b_sy_q;
  logic [11:0] b_start_q;

  always_comb begin
    eff_w = a_layer_q.rotate ? a_size_q[15:8] : a_size_q[7:0];
    eff_h = a_layer_q.rotate ? a_size_q[7:0]  : a_size_q[15:8];
    dx = {px_i[15], px_i} - {a_layer_q.pos_x[15], a_layer_q.pos_x};
    dy = {py_i[15], py_i} - {a_layer_q.pos_y[15], a_layer_q.pos_y};
    hit = !dx[16] && (dx < {9'b0, eff_w}) && !dy[16] && (dy < {9'b0, eff_h});
  end

  always_ff @(posedge clk_i) begin
    b_dx_q    <= dx[7:0];
    b_dy_q    <= dy[7:0];
    b_sx_q    <= a_layer_q.stride_x;
    b_sy_q    <= a_layer_q.stride_y;
    b_start_q <= a_layer_q.start;
  end

  // Stage C: stride products.
  logic signed [21:0] c_prx_q, c_pry_q;
  logic [11:0] c_start_q;

  always_ff @(posedge clk_i) begin
    c_prx_q   <= 22'($signed({1'b0, b_dx_q})) * 22'(b_sx_q);
    c_pry_q   <= 22'($signed({1'b0, b_dy_q})) * 22'(b_sy_q);
    c_start_q <= b_start_q;
  end

  // Stage D: address sum, biased to a positive value.
  logic signed [21:0] addr_sum;
  logic [22:0] d_u_q;

  assign addr_sum = $signed({10'b0, c_start_q}) + c_prx_q + c_pry_q;

  always_ff @(posedge clk_i) begin
    d_u_q <= {addr_sum[21], addr_sum} + OFFS;
  end

  // Stage E: quotient estimate by reciprocal.
  logic [40:0] q_prod;
  logic [17:0] e_q_q;
  logic [22:0] e_u_q;

  assign q_prod = 41'(d_u_q) * 41'(RECIP);

  always_ff @(posedge clk_i) begin
    e_q_q <= q_prod[40:23];
    e_u_q <= d_u_q;
  end

  // Stage F: remainder, below twice the store size.
  logic [22:0] q_back;
  logic [17:0] f_r_q;

  assign q_back = 23'(41'(e_q_q) * 41'(PIXELS));

  always_ff @(posedge clk_i) begin
    f_r_q <= 18'(e_u_q - q_back);
  end

  // Stage G: final correction and part pixel read.
  logic [AW-1:0] pix_addr;
  logic [7:0]    g_pix_q;

  assign pix_addr = (f_r_q >= 18'(PIXELS)) ? AW'(f_r_q - 18'(PIXELS)) : AW'(f_r_q);

  always_ff @(posedge clk_i) begin
    if (wr_pix_ok) begin
      pix_mem[AW'(wr_index_i)] <= wr_value_i[7:0];
    end
    g_pix_q <= pix_mem[pix_addr];
  end

  // Stage H: palette read.
  logic [31:0] h_col_q;

  always_ff @(posedge clk_i) begin
    if (wr_pal_ok) begin
      pal_mem[PLW'(wr_index_i)] <= wr_value_i;
    end
    h_col_q <= pal_mem[pal_lut[g_pix_q]];
  end

  // Control flags travel alongside the data; the hit test drops misses.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
      b_ctl_q <= '0;
      c_ctl_q <= '0;
      d_ctl_q <= '0;
      e_ctl_q <= '0;
      f_ctl_q <= '0;
      g_ctl_q <= '0;
      h_ctl_q <= '0;
    end else begin
      a_ctl_q      <= issue_i;
      b_ctl_q.live <= a_ctl_q.live && hit;
      b_ctl_q.last <= a_ctl_q.last;
      c_ctl_q      <= b_ctl_q;
      d_ctl_q      <= c_ctl_q;
      e_ctl_q      <= d_ctl_q;
      f_ctl_q      <= e_ctl_q;
      g_ctl_q      <= f_ctl_q;
      h_ctl_q      <= g_ctl_q;
    end
  end

  assign res_o   = h_ctl_q;
  assign color_o = h_col_q;

endmodule

// File: rtl/layered_sprite_pixel_compositor_core.sv
// Top level of the layered sprite pixel compositor: command port, layer ring, compositing.
// Depends on lspc_pkg, lspc_cell, lspc_pipe and assert_macros.svh.
`include "assert_macros.svh"

// Layered sprite pixel compositor. A word is accepted when start_i is high and
// busy_o is low. Table writes (layer, part size, part pixel, palette) complete at
// the accepting edge and give no result. A draw gives one result: color_o and
// covered_o, marked by result_valid_o for exactly one cycle; the receiver cannot
// stall it, so sample it when the strobe is high. With no frame active the draw
// repeats the last result in the cycle after acceptance and busy_o stays low.
// With a frame active the layer ring makes one full turn, one layer per cycle
// into an eight-stage pixel pipeline (part size read, hit test, stride
// multiply, address sum, two-step wrap, pixel read, palette read); the result
// is registered when the last layer leaves the pipeline, and busy_o stays high
// until then. The ring always makes the full turn, whatever layer_count is.
// Configuration writes are taken at any edge with cfg_we_i high and must be
// made while idle.
module layered_sprite_pixel_compositor_core #(
  parameter int LAYERS       = 16,
  parameter int PARTS        = 64,
  parameter int PIXELS       = 4096,
  parameter int PALETTE_SIZE = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [4:0]         cfg_data_i,
  // command word
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         command_i,
  input  logic [11:0]        index_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [5:0]         part_i,
  input  logic               rotate_i,
  input  logic [11:0]        start_req_i,
  input  logic signed [12:0] stride_x_i,
  input  logic signed [12:0] stride_y_i,
  input  logic [31:0]        value_i,
  input  logic [7:0]         part_width_i,
  input  logic [7:0]         part_height_i,
  // result word
  output logic               result_valid_o,
  output logic [31:0]        color_o,
  output logic               covered_o
);
  import lspc_pkg::*;

  localparam int SCW = $clog2(LAYERS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e         state_q;
  logic [SCW-1:0] step_q;
  logic           frame_active_q;
  logic [4:0]     layer_count_q;
  logic           valid_q;
  logic [31:0]    color_q;
  logic           covered_q;
  logic [31:0]    acc_color_q;
  logic           acc_cov_q;
  logic signed [15:0] px_q, py_q;

  // Command decode.
  logic     accept;
  logic     draw_acc;
  logic     layer_we;
  lspc_wr_t wr;

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    draw_acc = 1'b0;
    layer_we = 1'b0;
    wr       = '0;
    if (accept) begin
      case (command_i)
        CMD_DRAW:      draw_acc     = 1'b1;
        CMD_LAYER:     layer_we     = 1'b1;
        CMD_PART_SIZE: wr.part_size = 1'b1;
        CMD_PIXEL:     wr.pixel     = 1'b1;
        CMD_PALETTE:   wr.palette   = 1'b1;
        default:       ;
      endcase
    end
  end

  // Layer ring: cell 0 is the head; each step pulls every record one place down,
  // so after LAYERS steps the ring is back where it started.
  lspc_layer_t wr_layer;
  lspc_layer_t cell_layer [LAYERS];
  logic        issuing;

  always_comb begin
    wr_layer.pos_x    = pos_x_i;
    wr_layer.pos_y    = pos_y_i;
    wr_layer.part     = part_i;
    wr_layer.rotate   = rotate_i;
    wr_layer.start    = start_req_i;
    wr_layer.stride_x = stride_x_i;
    wr_layer.stride_y = stride_y_i;
  end

  assign issuing = (state_q == ST_RUN) && (step_q != SCW'(LAYERS));

  for (genvar k = 0; k < LAYERS; k++) begin : g_cell
    lspc_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (layer_we && (index_i == 12'(k))),
      .shift_i     (issuing),
      .wr_layer_i  (wr_layer),
      .nxt_layer_i (cell_layer[(k + 1) % LAYERS]),
      .layer_o     (cell_layer[k])
    );
  end

  // Layers past the saturated count still turn the ring but are not live.
  logic [6:0] n_sat;
  lspc_ctl_t  issue;

  assign n_sat = ({2'b0, layer_count_q} > 7'(LAYERS)) ? 7'(LAYERS) : {2'b0, layer_count_q};

  always_comb begin
    issue.live = issuing && (7'(step_q) < n_sat);
    issue.last = issuing && (step_q == SCW'(LAYERS - 1));
  end

  lspc_ctl_t   res_ctl;
  logic [31:0] res_color;

  lspc_pipe #(
    .PARTS        (PARTS),
    .PIXELS       (PIXELS),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .wr_index_i  (index_i),
    .wr_value_i  (value_i),
    .wr_width_i  (part_width_i),
    .wr_height_i (part_height_i),
    .issue_i     (issue),
    .layer_i     (cell_layer[0]),
    .px_i        (px_q),
    .py_i        (py_q),
    .res_o       (res_ctl),
    .color_o     (res_color)
  );

  // Compositing: an opaque pixel replaces the running color, last one wins.
  logic        hit_now;
  logic [31:0] new_color;
  logic        new_cov;

  assign hit_now   = res_ctl.live && (res_color[31:24] != 8'd0);
  assign new_color = hit_now ? res_color : acc_color_q;
  assign new_cov   = hit_now || acc_cov_q;

  // Hold the pixel coordinate for the whole draw.
  always_ff @(posedge clk_i) begin
    if (draw_acc) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      step_q         <= '0;
      frame_active_q <= 1'b0;
      layer_count_q  <= '0;
      valid_q        <= 1'b0;
      color_q        <= '0;
      covered_q      <= 1'b0;
      acc_color_q    <= '0;
      acc_cov_q      <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAME_ACTIVE: frame_active_q <= cfg_data_i[0];
          REG_LAYER_COUNT:  layer_count_q  <= cfg_data_i;
          default:          ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (draw_acc) begin
            if (frame_active_q) begin
              // Start a ring turn; seed the running color with the last result.
              state_q     <= ST_RUN;
              step_q      <= '0;
              acc_color_q <= color_q;
              acc_cov_q   <= 1'b0;
            end else begin
              // No frame: repeat the last result as it stands.
              valid_q <= 1'b1;
            end
          end
        end
        ST_RUN: begin
          if (issuing) begin
            step_q <= step_q + SCW'(1);
          end
          if (hit_now) begin
            acc_color_q <= res_color;
            acc_cov_q   <= 1'b1;
          end
          if (res_ctl.last) begin
            valid_q   <= 1'b1;
            color_q   <= new_color;
            covered_q <= new_cov;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q == ST_RUN);
  assign result_valid_o = valid_q;
  assign color_o        = color_q;
  assign covered_o      = covered_q;

  // A result is never shown while a draw is still in flight.
  `LSPC_NEVER(a_result_not_busy, result_valid_o && busy_o, "result strobe while busy")
  // The ring has made a full turn whenever a draw ends.
  `LSPC_ASSERT(a_ring_home, $fell(busy_o) |-> (step_q == SCW'(LAYERS)), "ring not home at draw end")
  // The end-of-draw marker only leaves the pipeline during a draw.
  `LSPC_ASSERT(a_last_in_run, res_ctl.last |-> (state_q == ST_RUN), "stray end-of-draw marker")

endmodule

// File: dv/tb.sv
// Self-checking testbench of the layered sprite pixel compositor core.
// Depends on lspc_pkg and layered_sprite_pixel_compositor_core; it drives command words,
// predicts every draw result itself and checks each strobed result word in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lspc_pkg::*;

  localparam int LAYERS       = 16;
  localparam int PARTS        = 64;
  localparam int PIXELS       = 4096;
  localparam int PALETTE_SIZE = 256;

  // Index widths of the shadow tables.
  localparam int LIW = $clog2(LAYERS);
  localparam int PIW = $clog2(PARTS);
  localparam int XIW = $clog2(PIXELS);
  localparam int CIW = $clog2(PALETTE_SIZE);

  // A full layer turn plus the pixel pipeline, with some margin.
  localparam int TAIL_CYCLES = LAYERS + 12;
  localparam int CYCLE_LIMIT = 1_500_000;

  // Command codes the block ignores.
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic [11:0]        index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [5:0]         part;
    logic               rotate;
    logic [11:0]        start_req;
    logic signed [12:0] stride_x;
    logic signed [12:0] stride_y;
    logic [31:0]        value;
    logic [7:0]         part_width;
    logic [7:0]         part_height;
  } cmd_word_t;

  typedef struct {
    logic [31:0] color;
    logic        covered;
  } pixel_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [4:0]         cfg_data_i;
  logic               start_i;
  logic               busy_o;
  logic [2:0]         command_i;
  logic [11:0]        index_i;
  logic signed [15:0] pos_x_i;
  logic signed [15:0] pos_y_i;
  logic [5:0]         part_i;
  logic               rotate_i;
  logic [11:0]        start_req_i;
  logic signed [12:0] stride_x_i;
  logic signed [12:0] stride_y_i;
  logic [31:0]        value_i;
  logic [7:0]         part_width_i;
  logic [7:0]         part_height_i;
  logic               result_valid_o;
  logic [31:0]        color_o;
  logic               covered_o;

  layered_sprite_pixel_compositor_core #(
    .LAYERS      (LAYERS),
    .PARTS       (PARTS),
    .PIXELS      (PIXELS),
    .PALETTE_SIZE(PALETTE_SIZE)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .index_i       (index_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .part_i        (part_i),
    .rotate_i      (rotate_i),
    .start_req_i   (start_req_i),
    .stride_x_i    (stride_x_i),
    .stride_y_i    (stride_y_i),
    .value_i       (value_i),
    .part_width_i  (part_width_i),
    .part_height_i (part_height_i),
    .result_valid_o(result_valid_o),
    .color_o       (color_o),
    .covered_o     (covered_o)
  );

  // Shadow of the block: registers, tables, written marks and the last result.
  logic        frame_on;
  logic [4:0]  layers_cfg;
  lspc_layer_t layer_tab [LAYERS];
  bit          layer_ok  [LAYERS];
  logic [7:0]  part_w    [PARTS];
  logic [7:0]  part_h    [PARTS];
  bit          part_ok   [PARTS];
  logic [7:0]  pix_tab   [PIXELS];
  bit          pix_ok    [PIXELS];
  logic [31:0] pal_tab   [PALETTE_SIZE];
  bit          pal_ok    [PALETTE_SIZE];
  logic [31:0] last_rgba;
  logic        last_hit;

  pixel_t      pixels_due[$];
  pixel_t      head;
  int          errors;
  int          words_sent;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Composite one pixel against the shadow tables. Return CMD_DRAW when the walk
  // is complete; otherwise return the table that would be read before it was
  // ever written, with the entry in hole, so the caller can fill it first.
  function automatic lspc_cmd_e composite(input logic signed [15:0] px,
                                          input logic signed [15:0] py,
                                          output logic [31:0] color,
                                          output logic covered,
                                          output int unsigned hole);
    int cx, cy, n, lx, ly, w, h, t, addr;
    logic [5:0] p;
    logic [7:0] slot;
    color   = last_rgba;
    covered = 1'b0;
    hole    = 0;
    if (!frame_on) begin
      // No frame: repeat color and coverage as they were.
      covered = last_hit;
      return CMD_DRAW;
    end
    cx = int'(px);
    cy = int'(py);
    n  = (int'(layers_cfg) > LAYERS) ? LAYERS : int'(layers_cfg);
    for (int i = 0; i < n; i++) begin
      if (!layer_ok[i]) begin
        hole = i;
        return CMD_LAYER;
      end
      p = 6'(layer_tab[i].part % PARTS);
      if (!part_ok[p]) begin
        hole = 32'(p);
        return CMD_PART_SIZE;
      end
      w = int'(part_w[p]);
      h = int'(part_h[p]);
      if (layer_tab[i].rotate) begin
        t = w;
        w = h;
        h = t;
      end
      lx = int'(layer_tab[i].pos_x);
      ly = int'(layer_tab[i].pos_y);
      if (cx < lx || cx >= lx + w || cy < ly || cy >= ly + h) continue;
      addr = int'(layer_tab[i].start) + (cy - ly) * int'(layer_tab[i].stride_y)
             + (cx - lx) * int'(layer_tab[i].stride_x);
      addr = addr % PIXELS;
      if (addr < 0) addr += PIXELS;
      if (!pix_ok[addr]) begin
        hole = addr;
        return CMD_PIXEL;
      end
      slot = 8'(pix_tab[addr] % PALETTE_SIZE);
      if (!pal_ok[slot]) begin
        hole = 32'(slot);
        return CMD_PALETTE;
      end
      // Any nonzero alpha wins over what lies below.
      if (pal_tab[slot][31:24] != 8'h00) begin
        color   = pal_tab[slot];
        covered = 1'b1;
      end
    end
    return CMD_DRAW;
  endfunction

  // Update the shadow for a word the block has just taken.
  function automatic void take_word(input cmd_word_t w);
    pixel_t      res;
    int unsigned hole;
    case (w.op)
      CMD_DRAW: begin
        void'(composite(w.pos_x, w.pos_y, res.color, res.covered, hole));
        last_rgba = res.color;
        last_hit  = res.covered;
        pixels_due.push_back(res);
      end
      CMD_LAYER: if (w.index < LAYERS) begin
        layer_tab[w.index[LIW-1:0]] = '{pos_x: w.pos_x, pos_y: w.pos_y, part: w.part,
                                        rotate: w.rotate, start: w.start_req,
                                        stride_x: w.stride_x, stride_y: w.stride_y};
        layer_ok[w.index[LIW-1:0]] = 1'b1;
      end
      CMD_PART_SIZE: if (w.index < PARTS) begin
        part_w[w.index[PIW-1:0]]  = w.part_width;
        part_h[w.index[PIW-1:0]]  = w.part_height;
        part_ok[w.index[PIW-1:0]] = 1'b1;
      end
      CMD_PIXEL: if (w.index < PIXELS) begin
        pix_tab[w.index[XIW-1:0]] = w.value[7:0];
        pix_ok[w.index[XIW-1:0]]  = 1'b1;
      end
      CMD_PALETTE: if (w.index < PALETTE_SIZE) begin
        pal_tab[w.index[CIW-1:0]] = w.value;
        pal_ok[w.index[CIW-1:0]]  = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Random content everywhere, so fields a command does not use still toggle.
  function automatic cmd_word_t rand_word();
    cmd_word_t w;
    w.op          = CMD_DRAW;
    w.index       = 12'($urandom);
    w.pos_x       = 16'($urandom);
    w.pos_y       = 16'($urandom);
    w.part        = 6'($urandom);
    w.rotate      = 1'($urandom);
    w.start_req   = 12'($urandom);
    w.stride_x    = 13'($urandom);
    w.stride_y    = 13'($urandom);
    w.value       = $urandom;
    w.part_width  = 8'($urandom);
    w.part_height = 8'($urandom);
    return w;
  endfunction

  function automatic cmd_word_t layer_word(input logic [11:0] idx,
                                           input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic [5:0] part, input logic rot,
                                           input logic [11:0] base,
                                           input logic signed [12:0] sx,
                                           input logic signed [12:0] sy);
    cmd_word_t w;
    w           = rand_word();
    w.op        = CMD_LAYER;
    w.index     = idx;
    w.pos_x     = x;
    w.pos_y     = y;
    w.part      = part;
    w.rotate    = rot;
    w.start_req = base;
    w.stride_x  = sx;
    w.stride_y  = sy;
    return w;
  endfunction

  function automatic cmd_word_t size_word(input logic [11:0] idx, input logic [7:0] wd,
                                          input logic [7:0] ht);
    cmd_word_t w;
    w             = rand_word();
    w.op          = CMD_PART_SIZE;
    w.index       = idx;
    w.part_width  = wd;
    w.part_height = ht;
    return w;
  endfunction

  function automatic cmd_word_t pixel_word(input logic [11:0] idx, input logic [31:0] val);
    cmd_word_t w;
    w       = rand_word();
    w.op    = CMD_PIXEL;
    w.index = idx;
    w.value = val;
    return w;
  endfunction

  function automatic cmd_word_t palette_word(input logic [11:0] idx, input logic [31:0] val);
    cmd_word_t w;
    w       = rand_word();
    w.op    = CMD_PALETTE;
    w.index = idx;
    w.value = val;
    return w;
  endfunction

  // Mostly small layers near the origin with short strides, sometimes anything.
  function automatic cmd_word_t rand_layer(input logic [11:0] idx);
    cmd_word_t w;
    w = layer_word(idx, 16'($urandom), 16'($urandom), 6'($urandom), 1'($urandom),
                   12'($urandom), 13'($urandom), 13'($urandom));
    if ($urandom_range(7) != 0) begin
      w.pos_x    = 16'(int'($urandom_range(80)) - 40);
      w.pos_y    = 16'(int'($urandom_range(80)) - 40);
      w.part     = 6'($urandom_range(15));
      w.stride_x = 13'(int'($urandom_range(16)) - 8);
      w.stride_y = 13'(int'($urandom_range(16)) - 8);
    end
    return w;
  endfunction

  function automatic cmd_word_t rand_size(input logic [11:0] idx);
    if ($urandom_range(7) != 0) begin
      return size_word(idx, 8'($urandom_range(24)), 8'($urandom_range(24)));
    end
    return size_word(idx, 8'($urandom), 8'($urandom));
  endfunction

  // A quarter of the colors are fully transparent.
  function automatic cmd_word_t rand_palette(input logic [11:0] idx);
    logic [31:0] val;
    val = $urandom;
    if ($urandom_range(3) == 0) val[31:24] = 8'h00;
    return palette_word(idx, val);
  endfunction

  // Present one word and hold it until the block takes it; start stays high
  // so a following word can go out without a gap.
  task automatic send_word(input cmd_word_t w);
    @(negedge clk_i);
    start_i       <= 1'b1;
    command_i     <= w.op;
    index_i       <= w.index;
    pos_x_i       <= w.pos_x;
    pos_y_i       <= w.pos_y;
    part_i        <= w.part;
    rotate_i      <= w.rotate;
    start_req_i   <= w.start_req;
    stride_x_i    <= w.stride_x;
    stride_y_i    <= w.stride_y;
    value_i       <= w.value;
    part_width_i  <= w.part_width;
    part_height_i <= w.part_height;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    take_word(w);
    words_sent++;
  endtask

  // Drop start for a number of cycles.
  task automatic hold_off(input int cycles);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Drop start, wait for every pending result, then let the pipeline drain.
  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] data);
    settle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == REG_FRAME_ACTIVE) frame_on = data[0];
    else layers_cfg = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Draw one pixel. First fill, with random content, every table entry the
  // draw would read before it was ever written; then send the draw itself.
  task automatic draw_at(input logic signed [15:0] px, input logic signed [15:0] py);
    cmd_word_t   w;
    lspc_cmd_e   gap;
    logic [31:0] color;
    logic        covered;
    int unsigned at;
    gap = composite(px, py, color, covered, at);
    while (gap != CMD_DRAW) begin
      case (gap)
        CMD_LAYER:     send_word(rand_layer(12'(at)));
        CMD_PART_SIZE: send_word(rand_size(12'(at)));
        CMD_PIXEL:     send_word(pixel_word(12'(at), $urandom));
        default:       send_word(rand_palette(12'(at)));
      endcase
      gap = composite(px, py, color, covered, at);
    end
    w       = rand_word();
    w.op    = CMD_DRAW;
    w.pos_x = px;
    w.pos_y = py;
    send_word(w);
  endtask

  // Before any frame: draws repeat the reset result and read no table.
  task automatic test_frame_off();
    draw_at(16'sh8000, 16'sh7FFF);
    draw_at(16'sh0000, 16'sh0000);
    write_reg(REG_LAYER_COUNT, 5'd3);
  endtask

  // Hand-built scene: overlap, transparency, rotation, address wrap in both
  // directions, field extremes, writes beyond the layer, part size and palette tables and spare commands.
  task automatic test_tables();
    write_reg(REG_FRAME_ACTIVE, 5'd1);
    send_word(palette_word(12'd0, 32'h0011_2233));
    send_word(palette_word(12'd1, 32'hFFFF_0000));
    send_word(palette_word(12'd2, 32'h8000_00FF));
    send_word(palette_word(12'(PALETTE_SIZE - 1), 32'h0100_FF00));
    send_word(palette_word(12'hFFF, 32'hFFFF_FFFF));
    send_word(size_word(12'd0, 8'd4, 8'd2));
    send_word(size_word(12'(PARTS - 1), 8'hFF, 8'hFF));
    send_word(size_word(12'hFFF, 8'd0, 8'd0));
    send_word(layer_word(12'd0, 16'sh0000, 16'sh0000, 6'd63, 1'b0, 12'd0, 13'sh0001,
                         -13'sd1));
    send_word(layer_word(12'd1, 16'sh7FFF, 16'sh8000, 6'd0, 1'b1, 12'hFFF, 13'sh0FFF,
                         13'sh1000));
    send_word(layer_word(12'd2, 16'sh0000, 16'sh0000, 6'd0, 1'b0, 12'd100, 13'sh0001,
                         13'sh0001));
    send_word(layer_word(12'hFFF, 16'sh0000, 16'sh0000, 6'd0, 1'b0, 12'd0, 13'sh0000,
                         13'sh0000));
    send_word(pixel_word(12'd0, 32'd1));
    send_word(pixel_word(12'd100, 32'd2));
    send_word(pixel_word(12'd101, 32'd0));
    send_word(pixel_word(12'(PIXELS - 1), 32'hFFFF_FFFF));
    draw_at(16'sd0, 16'sd0);
    draw_at(16'sd1, 16'sd0);
    draw_at(16'sd0, 16'sd1);
    draw_at(16'sh7FFF, 16'sh8000);
    draw_at(16'sh7FFF, -16'sd32765);
    draw_at(16'sh8000, 16'sh7FFF);
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
      cmd_word_t w;
      w    = rand_word();
      w.op = 3'(c);
      send_word(w);
    end
  endtask

  // Zero layers keep the color but clear coverage; counts above the table saturate.
  task automatic test_layer_count();
    write_reg(REG_LAYER_COUNT, 5'd0);
    draw_at(16'sd0, 16'sd0);
    write_reg(REG_LAYER_COUNT, 5'd31);
    draw_at(16'sd0, 16'sd0);
    draw_at(16'sd1, 16'sd1);
  endtask

  // Dropping the frame freezes color and coverage, whatever tables change.
  task automatic test_frame_hold();
    write_reg(REG_FRAME_ACTIVE, 5'd0);
    draw_at(16'sh7FFF, 16'sh7FFF);
    send_word(rand_palette(12'd1));
    draw_at(16'sd0, 16'sd0);
  endtask

  // One random phase at a fixed setting, counting every word sent, table fills
  // included. Most draws land on or next to a live layer so the hit test and
  // fetch path see real traffic.
  task automatic test_random_phase(input logic frame, input logic [4:0] count,
                                   input int words, input bit calm);
    int n, i, pick, goal;
    logic signed [15:0] px, py;
    cmd_word_t w;
    write_reg(REG_LAYER_COUNT, count);
    write_reg(REG_FRAME_ACTIVE, {4'b0, frame});
    n = (int'(count) > LAYERS) ? LAYERS : int'(count);
    goal = words_sent + words;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        i  = (n > 0) ? int'($urandom_range(n - 1)) : 0;
        px = 16'($urandom);
        py = 16'($urandom);
        if (pick < 45 && n > 0 && layer_ok[i]) begin
          px = 16'(int'(layer_tab[i].pos_x) + int'($urandom_range(27)) - 2);
          py = 16'(int'(layer_tab[i].pos_y) + int'($urandom_range(27)) - 2);
        end else if (pick < 50) begin
          px = 16'(int'($urandom_range(60)) - 30);
          py = 16'(int'($urandom_range(60)) - 30);
        end
        draw_at(px, py);
      end else if (pick < 65) begin
        send_word(rand_layer(12'(($urandom_range(9) == 0) ? $urandom
                                                           : $urandom_range(LAYERS - 1))));
      end else if (pick < 75) begin
        send_word(rand_size(12'(($urandom_range(9) == 0) ? $urandom
                                                          : $urandom_range(PARTS - 1))));
      end else if (pick < 88) begin
        send_word(pixel_word(12'($urandom_range(PIXELS - 1)), $urandom));
      end else if (pick < 97) begin
        send_word(rand_palette(12'(($urandom_range(9) == 0) ? $urandom
                                                             : $urandom_range(PALETTE_SIZE - 1))));
      end else begin
        w    = rand_word();
        w.op = CMD_SPARE_FIRST + 3'($urandom_range(CMD_SPARE_LAST - CMD_SPARE_FIRST));
        send_word(w);
      end
      if (!calm) begin
        if ($urandom_range(3) == 0) hold_off($urandom_range(1, 18));
        // Now and then hold everything back until the block is empty.
        if ($urandom_range(79) == 0) settle();
      end
    end
  endtask

  // Check every strobed result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual color %08h covered %0b",
                 $time, color_o, covered_o);
        errors++;
      end else begin
        head = pixels_due.pop_front();
        if (color_o !== head.color) begin
          $display("%0t: color mismatch, expected %08h actual %08h", $time, head.color,
                   color_o);
          errors++;
        end
        if (covered_o !== head.covered) begin
          $display("%0t: covered mismatch, expected %0b actual %0b", $time, head.covered,
                   covered_o);
          errors++;
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pixels_due.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    errors        = 0;
    words_sent    = 0;
    cycle_count   = 0;
    frame_on      = 1'b0;
    layers_cfg    = '0;
    last_rgba     = '0;
    last_hit      = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_FRAME_ACTIVE;
    cfg_data_i    = '0;
    start_i       = 1'b0;
    command_i     = CMD_DRAW;
    index_i       = '0;
    pos_x_i       = '0;
    pos_y_i       = '0;
    part_i        = '0;
    rotate_i      = 1'b0;
    start_req_i   = '0;
    stride_x_i    = '0;
    stride_y_i    = '0;
    value_i       = '0;
    part_width_i  = '0;
    part_height_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_frame_off();
    test_tables();
    test_layer_count();
    test_frame_hold();
    test_random_phase(1'b1, 5'd16, 250, 1'b0);
    test_random_phase(1'b1, 5'($urandom_range(2, 15)), 250, 1'b0);
    test_random_phase(1'b0, 5'd16, 100, 1'b0);
    test_random_phase(1'b1, 5'd1, 150, 1'b0);
    test_random_phase(1'b1, 5'd31, 200, 1'b0);
    // Close with back-to-back words and no idling.
    test_random_phase(1'b1, 5'd16, 300, 1'b1);
    settle();

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
